### src/sdta_pkg.sv
// Shared types and constants for the signed decimal to ASCII unit.
package sdta_pkg;

  // ASCII codes used in the output text.
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new value and take its magnitude
    logic shift;       // one double-dabble step
    logic emit_sign;   // load a minus sign into the output register
    logic emit_digit;  // load the current digit into the output register
    logic step_digit;  // move to the next lower digit
  } sdta_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bit_last;    // the current shift is the final one
    logic neg;         // the captured value is negative
    logic digit_zero;  // the current digit is zero
    logic idx_zero;    // the current digit is the units digit
    logic started;     // a digit has already been sent
  } sdta_status_t;

endpackage

### src/signed_decimal_to_ascii_unit.sv
// Top level of the signed decimal to ASCII unit.
//
//   Channel  Signals                                 Direction
//   input    in_valid, in_ready, value               one number per transaction
//   output   out_valid, out_ready, character, last   one character per transaction
//
// A number is taken in the idle state, then the magnitude goes through VALUE_WIDTH
// shift-add-3 steps, one bit per cycle, then the digit scan walks the digit
// positions from the most significant down (10 for 32 bits), passing over leading
// zeros and sending a minus sign first when the number is negative.
// Reset (synchronous, active high) returns the controller to idle and empties
// the output register. A stalled output holds the sequencer; a new number is
// taken while the final character still waits in the output register.
module signed_decimal_to_ascii_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [6:0]             character,
  output logic                   last
);
  import sdta_pkg::*;

  sdta_cmd_t    cmd;
  sdta_status_t status;

  // Sequencer.
  sdta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Conversion and output data.
  sdta_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (last)
  );

endmodule

### src/sdta_datapath.sv
// Datapath: magnitude capture, shift-add-3 BCD conversion and output register.
module sdta_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic [VALUE_WIDTH-1:0]    value,
  input  sdta_pkg::sdta_cmd_t       cmd,
  output sdta_pkg::sdta_status_t    status,
  output logic [6:0]                character,
  output logic                      last
);
  import sdta_pkg::*;

  // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
  localparam int DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BW     = $clog2(VALUE_WIDTH);
  localparam int IW     = $clog2(DIGITS);

  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic [BW-1:0]          bit_cnt;
  logic [IW-1:0]          idx;
  logic                   started;
  logic [3:0]             bcd      [DIGITS];
  logic [3:0]             bcd_next [DIGITS];
  logic [3:0]             adj      [DIGITS];
  logic [3:0]             cur_digit;

  // Add three to every digit of five or more, then shift in the next bit.
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      adj[d] = (bcd[d] >= 4'd5) ? bcd[d] + 4'd3 : bcd[d];
    end
    for (int d = 0; d < DIGITS; d++) begin
      if (d == 0) begin
        bcd_next[d] = {adj[d][2:0], mag[VALUE_WIDTH-1]};
      end else begin
        bcd_next[d] = {adj[d][2:0], adj[d-1][3]};
      end
    end
  end

  assign cur_digit = bcd[idx];

  // Status toward the controller.
  always_comb begin
    status.bit_last   = (bit_cnt == BW'(VALUE_WIDTH - 1));
    status.neg        = neg;
    status.digit_zero = (cur_digit == 4'd0);
    status.idx_zero   = (idx == '0);
    status.started    = started;
  end

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[VALUE_WIDTH-1];
      mag     <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      bit_cnt <= '0;
      idx     <= IW'(DIGITS - 1);
      started <= 1'b0;
      for (int d = 0; d < DIGITS; d++) begin
        bcd[d] <= 4'd0;
      end
    end else if (cmd.shift) begin
      mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
      for (int d = 0; d < DIGITS; d++) begin
        bcd[d] <= bcd_next[d];
      end
    end else begin
      if (cmd.step_digit) begin
        idx <= idx - 1'b1;
      end
      if (cmd.emit_digit) begin
        started <= 1'b1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= CHAR_ZERO + {3'b000, cur_digit};
      last      <= (idx == '0);
    end
  end

endmodule

### src/sdta_ctrl.sv
// Controller: sequences capture, conversion and character output.
module sdta_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  sdta_pkg::sdta_status_t  status,
  output sdta_pkg::sdta_cmd_t     cmd
);
  import sdta_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    SIGN,
    EMIT
  } state_t;

  state_t state;
  logic   space;
  logic   skip;

  // The output register can take a character when empty or being drained.
  assign space    = !out_valid || out_ready;
  assign in_ready = (state == IDLE);
  // Leading zeros are passed over, but the units digit is always sent.
  assign skip     = !status.started && status.digit_zero && !status.idx_zero;

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.load = in_valid;
      end
      CONVERT: begin
        cmd.shift = 1'b1;
      end
      SIGN: begin
        cmd.emit_sign = space;
      end
      EMIT: begin
        if (skip) begin
          cmd.step_digit = 1'b1;
        end else if (space) begin
          cmd.emit_digit = 1'b1;
          cmd.step_digit = !status.idx_zero;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CONVERT;
          end
        end
        CONVERT: begin
          if (status.bit_last) begin
            state <= status.neg ? SIGN : EMIT;
          end
        end
        SIGN: begin
          if (space) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (cmd.emit_digit && status.idx_zero) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
